// ===== rtl/substring_end_search_core_assert.svh =====
// Assertion macros shared by the substring search checker.
`ifndef SUBSTRING_END_SEARCH_CORE_ASSERT_SVH
`define SUBSTRING_END_SEARCH_CORE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define SESC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SESC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sesc_pkg.sv =====
// Types and constants shared by the substring end search modules.
package sesc_pkg;

    localparam int BYTE_W        = 8;
    localparam int POS_W         = 8;
    localparam int LEN_W         = 5;
    localparam int CFG_W         = 64;
    localparam int CFG_INDEX_W   = 2;
    localparam int PATTERN_BYTES = 16;
    localparam int PAT_SEL_W     = $clog2(PATTERN_BYTES);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = 1;
    localparam int QUEUE_CNT_W   = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    // One classified item passed from the front part to the back part.
    typedef struct packed {
        logic             last;
        logic             hit;
        logic [POS_W-1:0] pos;
    } qentry_t;

endpackage

// ===== rtl/substring_end_search_core.sv =====
// Top level of the streaming substring end search.
//
//  Channel  Direction  Handshake             Payload
//  input    in         in_valid / in_stall   text_byte, last
//  output   out        out_valid / out_stall found, end_position
//  config   in         cfg_write             cfg_index, cfg_data
//
// One text byte is taken per cycle unless the queue is full. The front part
// compares the whole window combinationally and pushes a classified item into a
// two-entry queue; the back part drains one item per cycle and registers each result.
// An asynchronous active-low reset clears the pattern, window, counters and queue.
// A stalled result stays in the output register while input items keep flowing until
// the queue fills; only the last item of a text waits on a free output register.
//
// The block streams bytes into a window of the latest PATTERN_MAX bytes. Each byte is
// tagged as a hit when the newest pattern_length window bytes equal the pattern, with
// its 1-based position in the text. Bytes beyond TEXT_MAX are neither shifted in nor
// counted. The back part keeps the first hit of the text and, on the item marked last,
// reports it and clears itself; the front part clears its window at the same point.
module substring_end_search_core
#(
    parameter int PATTERN_MAX = 16,
    parameter int TEXT_MAX    = 255
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [sesc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sesc_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sesc_pkg::BYTE_W-1:0]       text_byte,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              found,
    output logic [sesc_pkg::POS_W-1:0]        end_position
);

    // Classified items travelling from the front part to the back part.
    logic              push;
    logic              q_full;
    logic              pop;
    logic              head_valid;
    sesc_pkg::qentry_t push_entry;
    sesc_pkg::qentry_t head_entry;

    sesc_front
    #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .last       (last),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // The queue lets the front part keep taking bytes while a result waits.
    sesc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    sesc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .end_position (end_position)
    );

endmodule

// ===== rtl/sesc_queue.sv =====
// Two-entry queue of classified items between the front and back parts.
module sesc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sesc_pkg::qentry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output sesc_pkg::qentry_t head_entry
);

    sesc_pkg::qentry_t slot_reg [sesc_pkg::QUEUE_DEPTH];

    logic [sesc_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [sesc_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [sesc_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [sesc_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [sesc_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [sesc_pkg::QUEUE_CNT_W-1:0] count_next;

    assign full       = (count_reg == sesc_pkg::QUEUE_CNT_W'(sesc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/sesc_front.sv =====
// Front part: pattern registers, byte window and per-byte match classification.
module sesc_front
#(
    parameter int PATTERN_MAX = 16,
    parameter int TEXT_MAX    = 255
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [sesc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sesc_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sesc_pkg::BYTE_W-1:0]       text_byte,
    input  logic                              last,
    input  logic                              q_full,
    output logic                              push,
    output sesc_pkg::qentry_t                 push_entry
);

    logic [sesc_pkg::CFG_W-1:0] pat_low_reg;
    logic [sesc_pkg::CFG_W-1:0] pat_low_next;
    logic [sesc_pkg::CFG_W-1:0] pat_high_reg;
    logic [sesc_pkg::CFG_W-1:0] pat_high_next;
    logic [sesc_pkg::LEN_W-1:0] pat_len_reg;
    logic [sesc_pkg::LEN_W-1:0] pat_len_next;

    logic [sesc_pkg::BYTE_W-1:0] window_reg  [PATTERN_MAX];
    logic [sesc_pkg::BYTE_W-1:0] window_next [PATTERN_MAX];
    logic [sesc_pkg::BYTE_W-1:0] shifted     [PATTERN_MAX];
    logic [sesc_pkg::BYTE_W-1:0] pat_byte    [sesc_pkg::PATTERN_BYTES];
    logic [sesc_pkg::POS_W-1:0]  count_reg;
    logic [sesc_pkg::POS_W-1:0]  count_next;
    logic [sesc_pkg::POS_W-1:0]  count_plus;

    logic [2*sesc_pkg::CFG_W-1:0]   pat_all;
    logic [PATTERN_MAX-1:0]         lane_ok;
    logic [sesc_pkg::LEN_W-1:0]     lane_sel [PATTERN_MAX];
    logic                           accept;
    logic                           room;
    logic                           len_ok;
    logic                           enough;
    logic                           hit;

    // Configuration writes.
    always_comb
    begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        pat_len_next  = pat_len_reg;
        if (cfg_write)
        begin
            unique case (sesc_pkg::cfg_reg_t'(cfg_index))
                sesc_pkg::CFG_PATTERN_LOW:    pat_low_next  = cfg_data;
                sesc_pkg::CFG_PATTERN_HIGH:   pat_high_next = cfg_data;
                sesc_pkg::CFG_PATTERN_LENGTH: pat_len_next  = cfg_data[sesc_pkg::LEN_W-1:0];
                default:                      pat_len_next  = pat_len_reg;
            endcase
        end
    end

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;
    assign pat_all  = {pat_high_reg, pat_low_reg};

    assign room       = (count_reg < sesc_pkg::POS_W'(TEXT_MAX));
    assign count_plus = count_reg + 1'b1;
    assign len_ok     = (pat_len_reg != '0) && (pat_len_reg <= sesc_pkg::LEN_W'(PATTERN_MAX));
    assign enough     = (sesc_pkg::POS_W'(pat_len_reg) <= count_plus);

    always_comb
    begin
        for (int j = 0; j < sesc_pkg::PATTERN_BYTES; j++)
        begin
            pat_byte[j] = pat_all[j*sesc_pkg::BYTE_W +: sesc_pkg::BYTE_W];
        end
        shifted[0] = text_byte;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            shifted[k] = window_reg[k-1];
        end
        // Window entry i (0 newest) lines up with pattern byte len-1-i.
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            lane_sel[i] = pat_len_reg - sesc_pkg::LEN_W'(i) - sesc_pkg::LEN_W'(1);
            lane_ok[i]  = (sesc_pkg::LEN_W'(i) >= pat_len_reg) ||
                          (shifted[i] == pat_byte[lane_sel[i][sesc_pkg::PAT_SEL_W-1:0]]);
        end
    end

    assign hit = room && len_ok && enough && (&lane_ok);

    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        if (accept)
        begin
            if (last)
            begin
                for (int k = 0; k < PATTERN_MAX; k++)
                begin
                    window_next[k] = '0;
                end
                count_next = '0;
            end
            else if (room)
            begin
                window_next = shifted;
                count_next  = count_plus;
            end
        end
    end

    assign push            = accept;
    assign push_entry.last = last;
    assign push_entry.hit  = hit;
    assign push_entry.pos  = count_plus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            count_reg    <= '0;
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                window_reg[k] <= '0;
            end
        end
        else
        begin
            pat_low_reg  <= pat_low_next;
            pat_high_reg <= pat_high_next;
            pat_len_reg  <= pat_len_next;
            count_reg    <= count_next;
            window_reg   <= window_next;
        end
    end

endmodule

// ===== rtl/sesc_back.sv =====
// Back part: keeps the first match of a text and reports it on the last item.
module sesc_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  sesc_pkg::qentry_t             head_entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [sesc_pkg::POS_W-1:0]    end_position
);

    logic                         seen_reg;
    logic                         seen_next;
    logic [sesc_pkg::POS_W-1:0]   pos_reg;
    logic [sesc_pkg::POS_W-1:0]   pos_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         found_reg;
    logic                         found_next;
    logic [sesc_pkg::POS_W-1:0]   end_pos_reg;
    logic [sesc_pkg::POS_W-1:0]   end_pos_next;

    logic                         out_free;
    logic                         eff_seen;
    logic [sesc_pkg::POS_W-1:0]   eff_pos;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = head_valid && (!head_entry.last || out_free);

    // Only the first hit of a text counts.
    assign eff_seen = seen_reg || head_entry.hit;
    assign eff_pos  = seen_reg ? pos_reg : head_entry.pos;

    always_comb
    begin
        seen_next      = seen_reg;
        pos_next       = pos_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        found_next     = found_reg;
        end_pos_next   = end_pos_reg;
        if (pop)
        begin
            if (head_entry.last)
            begin
                out_valid_next = 1'b1;
                found_next     = eff_seen && (eff_pos != '0);
                end_pos_next   = eff_seen ? eff_pos : '0;
                seen_next      = 1'b0;
                pos_next       = '0;
            end
            else
            begin
                seen_next = eff_seen;
                pos_next  = eff_seen ? eff_pos : '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign end_position = end_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg   <= found_next;
        end_pos_reg <= end_pos_next;
    end

endmodule

// ===== rtl/sesc_checker.sv =====
// Port-level checker for the substring end search core and its bind.
`include "substring_end_search_core_assert.svh"

module sesc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          found,
    input logic [sesc_pkg::POS_W-1:0]    end_position
);

    // A stalled result must hold until it is taken.
    `SESC_ASSERT(a_out_hold,
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(end_position),
        "stalled result changed")

    // The found flag agrees with a nonzero end position.
    `SESC_ASSERT(a_found_pos, out_valid |-> (found == (end_position != '0)), "found disagrees with end position")

    // Once reset has been held over a clock edge, no result is offered.
    `SESC_ASSERT_ALWAYS(a_reset_quiet, !rst_n ##1 !rst_n |=> !out_valid, "result offered during reset")

endmodule

bind substring_end_search_core sesc_checker u_sesc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .end_position (end_position)
);
